/* design/priority_ready_queue_assert.svh */
// Assertion macros used by the checker file of the ready queue.
// Depends on nothing; include by bare file name.
`ifndef PRIORITY_READY_QUEUE_ASSERT_SVH
`define PRIORITY_READY_QUEUE_ASSERT_SVH

// same-cycle implication, reset masked
`define PRQ_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error("priority_ready_queue assertion failed");

// next-cycle implication, reset masked
`define PRQ_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error("priority_ready_queue assertion failed");

`endif

/* design/prq_pkg.sv */
// Package of the priority ready queue: command and status codes, cell link types.
// Depends on nothing.
`default_nettype none
package prq_pkg;

	localparam int TID_W  = 4;
	localparam int PRI_W  = 8;
	localparam int MASK_W = 16;
	localparam int CNT_W  = 4;
	localparam int STAT_W = 2;

	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STAT_W-1:0] ST_REMOVED  = 2'd2;
	localparam logic [STAT_W-1:0] ST_NONE     = 2'd3;

	typedef struct packed {
		logic              ins_en;
		logic              rem_en;
		logic [TID_W-1:0]  tid;
		logic [PRI_W-1:0]  pri;
		logic [MASK_W-1:0] mask;
	} prq_op_t;

	typedef struct packed {
		logic [TID_W-1:0] tid;
		logic [PRI_W-1:0] pri;
	} prq_entry_t;

	typedef struct packed {
		logic             ahead;
		logic             hit;
		logic [TID_W-1:0] tid_acc;
		prq_entry_t       ent;
	} prq_link_t;

endpackage
`default_nettype wire

/* design/prq_cell.sv */
// One slot of the sorted queue: holds an entry, shifts right on insert, left on removal.
// Depends on prq_pkg.
`default_nettype none
module prq_cell
	import prq_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       live,
	input  wire prq_op_t    op,
	input  wire prq_link_t  left,
	input  wire prq_entry_t right,
	output prq_link_t       link
);

	prq_entry_t ent_q;
	logic       ahead;
	logic       match;
	logic       first;

	always_comb begin
		ahead = live && (ent_q.pri <= op.pri);
		match = live && op.mask[ent_q.tid];
		first = match && !left.hit;
		link.ahead   = ahead;
		link.hit     = left.hit | match;
		link.tid_acc = left.tid_acc | (first ? ent_q.tid : '0);
		link.ent     = ent_q;
	end

	always_ff @(posedge clk) begin
		if (op.ins_en && !ahead) begin
			if (left.ahead) begin
				ent_q.tid <= op.tid;
				ent_q.pri <= op.pri;
			end else begin
				ent_q <= left.ent;
			end
		end else if (op.rem_en && (left.hit || match)) begin
			ent_q <= right;
		end
	end

endmodule
`default_nettype wire

/* design/priority_ready_queue.sv */
// Channel  Dir  Payload (low bit first)                         Transaction
// s        in   tuser: cmd; tdata: task_id, priority_req, mask   s_tvalid & s_tready
// m        out  tuser: status; tdata: task_out, count_out        m_tvalid & m_tready
//
// Each item is captured, then makes one compare-and-shift pass through the cell row.
// The result register frees the input as soon as the pass is done.
// A pass waits while a previous result is still held and not taken.
// arst_n clears the entry count and handshake state; entry contents are not cleared.
// Top level of the priority ready queue; depends on prq_pkg and prq_cell.
`default_nettype none
module priority_ready_queue
	import prq_pkg::*;
#(
	parameter int MAX_TASKS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // task_id[3:0], priority_req[11:4], eligible_mask[27:12]
	input  wire logic        s_tuser,  // cmd
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,  // task_out[3:0], count_out[7:4]
	output logic [1:0]       m_tuser   // status
);

	localparam int CAP = MAX_TASKS - 1;
	localparam int CW  = $clog2(MAX_TASKS);

	logic              busy_q;
	logic              cmd_q;
	logic [TID_W-1:0]  tid_q;
	logic [PRI_W-1:0]  pri_q;
	logic [MASK_W-1:0] mask_q;
	logic [CW-1:0]     count_q;
	logic              out_valid_q;
	logic [STAT_W-1:0] out_status_q;
	logic [TID_W-1:0]  out_tid_q;
	logic [CNT_W-1:0]  out_count_q;

	logic              exec;
	logic              full;
	logic [CW-1:0]     count_nxt;
	logic [CW+CNT_W-1:0] count_ext;
	prq_op_t           op;
	prq_link_t         lnk [0:CAP];
	prq_entry_t        rgt [0:CAP-1];

	assign s_tready = !busy_q;
	assign exec     = busy_q && (!out_valid_q || m_tready);
	assign full     = (count_q == CW'(CAP));

	always_comb begin
		op.ins_en = exec && (cmd_q == CMD_ENQ) && !full;
		op.rem_en = exec && (cmd_q == CMD_DEQ);
		op.tid    = tid_q;
		op.pri    = pri_q;
		op.mask   = mask_q;
		lnk[0]    = '0;
		lnk[0].ahead = 1'b1;
	end

	for (genvar i = 0; i < CAP; i++) begin : g_cell
		if (i < CAP - 1) begin : g_mid
			assign rgt[i] = lnk[i+2].ent;
		end else begin : g_end
			assign rgt[i] = '0;
		end
		prq_cell u_cell (
			.clk   (clk),
			.live  (count_q > CW'(i)),
			.op    (op),
			.left  (lnk[i]),
			.right (rgt[i]),
			.link  (lnk[i+1])
		);
	end

	always_comb begin
		count_nxt = count_q;
		if (op.ins_en) begin
			count_nxt = count_q + CW'(1);
		end else if (op.rem_en && lnk[CAP].hit) begin
			count_nxt = count_q - CW'(1);
		end
		count_ext = {{CNT_W{1'b0}}, count_nxt};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				busy_q <= 1'b1;
			end else if (exec) begin
				busy_q <= 1'b0;
			end
			if (exec) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q  <= s_tuser;
			tid_q  <= s_tdata[3:0];
			pri_q  <= s_tdata[11:4];
			mask_q <= s_tdata[27:12];
		end
		if (exec) begin
			out_count_q <= count_ext[CNT_W-1:0];
			if (cmd_q == CMD_ENQ) begin
				out_status_q <= full ? ST_FULL : ST_INSERTED;
				out_tid_q    <= '0;
			end else if (lnk[CAP].hit) begin
				out_status_q <= ST_REMOVED;
				out_tid_q    <= lnk[CAP].tid_acc;
			end else begin
				out_status_q <= ST_NONE;
				out_tid_q    <= '0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_count_q, out_tid_q};
	assign m_tuser  = out_status_q;

endmodule
`default_nettype wire

/* design/prq_checker.sv */
// Port-level checker for the priority ready queue, bound to the top level.
// Depends on prq_pkg and priority_ready_queue_assert.svh.
`default_nettype none
`include "priority_ready_queue_assert.svh"
module prq_checker
	import prq_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tvalid,
	input wire logic       s_tready,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic [1:0] m_tuser
);

	`PRQ_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	`PRQ_ASSERT_NOW(a_task_zero, clk, arst_n, m_tvalid && (m_tuser != ST_REMOVED), m_tdata[3:0] == 4'd0)
	`PRQ_ASSERT_NEXT(a_one_in_flight, clk, arst_n, s_tvalid && s_tready, !s_tready)

endmodule

bind priority_ready_queue prq_checker u_prq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire

/* test/tb_priority_ready_queue.sv */
// Testbench for priority_ready_queue: a directed table, then random enqueue and dequeue traffic.
// Results are checked against the table's expected values where given, else against a sorted-queue predictor kept here.
// Depends on prq_pkg and the priority_ready_queue RTL.
`timescale 1ns / 1ps
module tb_priority_ready_queue;
	import prq_pkg::*;

	localparam int MAX_TASKS    = 16;
	localparam int CAPACITY     = MAX_TASKS - 1;
	localparam int PHASE_ITEMS  = 150;
	localparam int HOLD_AT      = 55;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [TID_W-1:0]  tsk;
		logic [CNT_W-1:0]  count;
	} outcome_t;

	typedef struct {
		logic              c;
		logic [TID_W-1:0]  tid;
		logic [PRI_W-1:0]  pri;
		logic [MASK_W-1:0] mask;
		bit                known;
		outcome_t          want;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic [1:0]  m_tuser;

	logic [TID_W-1:0] rq_task [CAPACITY];
	logic [PRI_W-1:0] rq_prio [CAPACITY];
	int               rq_count = 0;

	outcome_t pending_outcomes [$];
	dir_row_t dir_rows [$];
	int       errors = 0;
	int       accepted_items = 0;
	int       send_idle_pct = 0;
	int       recv_stall_pct = 0;

	priority_ready_queue #(.MAX_TASKS(MAX_TASKS)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("[priority_ready_queue] ERROR");
		$finish;
	end

	function automatic outcome_t serve_request(input logic c, input logic [TID_W-1:0] tid,
			input logic [PRI_W-1:0] pri, input logic [MASK_W-1:0] mask);
		outcome_t o;
		int pos;
		int k;
		o = '0;
		if (c == CMD_ENQ) begin
			if (rq_count >= CAPACITY) begin
				o.status = ST_FULL;
			end else begin
				pos = 0;
				while (pos < rq_count && rq_prio[pos] <= pri) pos++;
				for (k = rq_count; k > pos; k--) begin
					rq_task[k] = rq_task[k-1];
					rq_prio[k] = rq_prio[k-1];
				end
				rq_task[pos] = tid;
				rq_prio[pos] = pri;
				rq_count++;
				o.status = ST_INSERTED;
			end
		end else begin
			pos = 0;
			while (pos < rq_count && !mask[rq_task[pos]]) pos++;
			if (pos < rq_count) begin
				o.tsk = rq_task[pos];
				for (k = pos; k + 1 < rq_count; k++) begin
					rq_task[k] = rq_task[k+1];
					rq_prio[k] = rq_prio[k+1];
				end
				rq_count--;
				o.status = ST_REMOVED;
			end else begin
				o.status = ST_NONE;
			end
		end
		o.count = rq_count[CNT_W-1:0];
		return o;
	endfunction

	task automatic add_row(input logic c, input int tid, input int pri, input int mask,
			input bit known, input logic [STAT_W-1:0] st, input int tsk, input int cnt);
		dir_row_t r;
		r.c = c;
		r.tid = tid[TID_W-1:0];
		r.pri = pri[PRI_W-1:0];
		r.mask = mask[MASK_W-1:0];
		r.known = known;
		r.want.status = st;
		r.want.tsk = tsk[TID_W-1:0];
		r.want.count = cnt[CNT_W-1:0];
		dir_rows.push_back(r);
	endtask

	task automatic send_item(input logic c, input logic [TID_W-1:0] tid,
			input logic [PRI_W-1:0] pri, input logic [MASK_W-1:0] mask,
			input bit known, input outcome_t want);
		outcome_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= c;
		s_tdata <= {4'b0, mask, pri, tid};
		do @(posedge clk); while (!s_tready);
		predicted = serve_request(c, tid, pri, mask);
		pending_outcomes.push_back(known ? want : predicted);
		accepted_items++;
	endtask

	initial begin : result_side
		int held;
		bit hold_done;
		outcome_t want;
		held = 0;
		hold_done = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (pending_outcomes.size() == 0) begin
					errors++;
					$display("%0t: result with none expected: status %0d task %0d count %0d",
						$time, m_tuser, m_tdata[3:0], m_tdata[7:4]);
				end else begin
					want = pending_outcomes.pop_front();
					if (m_tuser !== want.status) begin
						errors++;
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, m_tuser);
					end
					if (m_tdata[3:0] !== want.tsk) begin
						errors++;
						$display("%0t: task_out expected %0d actual %0d",
							$time, want.tsk, m_tdata[3:0]);
					end
					if (m_tdata[7:4] !== want.count) begin
						errors++;
						$display("%0t: count_out expected %0d actual %0d",
							$time, want.count, m_tdata[7:4]);
					end
				end
			end
			if (!hold_done && accepted_items >= HOLD_AT) begin
				hold_done = 1;
				held = HOLD_CYCLES;
			end
			if (held > 0) begin
				held--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	initial begin : stimulus
		int ph;
		int i;
		int enq_bias;
		int sel;
		logic c;
		logic [TID_W-1:0] tid;
		logic [PRI_W-1:0] pri;
		logic [MASK_W-1:0] mask;

		add_row(CMD_DEQ, 0, 0, 'hFFFF, 1, ST_NONE, 0, 0);
		add_row(CMD_ENQ, 15, 255, 'h0000, 1, ST_INSERTED, 0, 1);
		add_row(CMD_ENQ, 0, 0, 'hFFFF, 1, ST_INSERTED, 0, 2);
		add_row(CMD_ENQ, 5, 0, 'h0000, 0, ST_INSERTED, 0, 0);
		add_row(CMD_ENQ, 9, 128, 'h0000, 0, ST_INSERTED, 0, 0);
		add_row(CMD_ENQ, 3, 128, 'h5A5A, 0, ST_INSERTED, 0, 0);
		add_row(CMD_ENQ, 12, 255, 'h0000, 0, ST_INSERTED, 0, 0);
		add_row(CMD_ENQ, 6, 1, 'h0000, 0, ST_INSERTED, 0, 0);
		add_row(CMD_ENQ, 10, 254, 'h0000, 0, ST_INSERTED, 0, 0);
		add_row(CMD_ENQ, 1, 127, 'h0000, 0, ST_INSERTED, 0, 0);
		add_row(CMD_ENQ, 2, 129, 'h0000, 0, ST_INSERTED, 0, 0);
		add_row(CMD_ENQ, 7, 0, 'h0000, 0, ST_INSERTED, 0, 0);
		add_row(CMD_ENQ, 8, 64, 'h0000, 0, ST_INSERTED, 0, 0);
		add_row(CMD_ENQ, 11, 200, 'h0000, 0, ST_INSERTED, 0, 0);
		add_row(CMD_ENQ, 4, 32, 'h0000, 0, ST_INSERTED, 0, 0);
		add_row(CMD_ENQ, 13, 128, 'h0000, 1, ST_INSERTED, 0, 15);
		add_row(CMD_ENQ, 14, 0, 'hFFFF, 1, ST_FULL, 0, 15);
		add_row(CMD_DEQ, 15, 255, 'h0000, 1, ST_NONE, 0, 15);
		add_row(CMD_DEQ, 15, 255, 'hFFFF, 0, ST_NONE, 0, 0);
		add_row(CMD_DEQ, 0, 0, 'h8000, 0, ST_NONE, 0, 0);
		add_row(CMD_DEQ, 0, 0, 'h1208, 0, ST_NONE, 0, 0);
		add_row(CMD_DEQ, 0, 0, 'h4000, 0, ST_NONE, 0, 0);
		add_row(CMD_DEQ, 0, 0, 'h0080, 0, ST_NONE, 0, 0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r])
			send_item(dir_rows[r].c, dir_rows[r].tid, dir_rows[r].pri, dir_rows[r].mask,
				dir_rows[r].known, dir_rows[r].want);

		enq_bias = 50;
		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
				default: begin send_idle_pct = 22; recv_stall_pct = 22; end
			endcase
			for (i = 0; i < PHASE_ITEMS; i++) begin
				if (i % 40 == 0) begin
					case ($urandom_range(2))
						0: enq_bias = 85;
						1: enq_bias = 50;
						default: enq_bias = 15;
					endcase
				end
				c = ($urandom_range(99) < enq_bias) ? CMD_ENQ : CMD_DEQ;
				tid = TID_W'($urandom_range(15));
				pri = PRI_W'($urandom_range(1) ? $urandom_range(3) : $urandom_range(255));
				sel = $urandom_range(9);
				if (sel <= 3)
					mask = MASK_W'($urandom_range(16'hFFFF));
				else if (sel <= 5)
					mask = '1;
				else if (sel == 6)
					mask = '0;
				else if (rq_count > 0)
					mask = 16'(1) << rq_task[$urandom_range(rq_count - 1)];
				else
					mask = 16'(1) << $urandom_range(15);
				send_item(c, tid, pri, mask, 0, '0);
			end
		end
		s_tvalid <= 1'b0;

		while (pending_outcomes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending_outcomes.size() == 0)
			$display("[priority_ready_queue] OK");
		else
			$display("[priority_ready_queue] ERROR");
		$finish;
	end

endmodule
